// ----- rtl/core/half_block_ansi_color_encoder_macros.svh -----
// Assertion macros for the half-block color encoder checker.
// Used by hbe_checker.sv; no other dependencies.
`ifndef HALF_BLOCK_ANSI_COLOR_ENCODER_MACROS_SVH
`define HALF_BLOCK_ANSI_COLOR_ENCODER_MACROS_SVH

// same-cycle implication, async active-low reset
`define HBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hbe assertion failed");

// next-cycle implication
`define HBE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hbe assertion failed");

`endif

// ----- rtl/core/hbe_pkg.sv -----
// Types, constants and helper functions for the half-block color encoder.
// No dependencies.
`default_nettype none

package hbe_pkg;

	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;

	// one color value, already split into decimal digits
	typedef struct packed {
		logic [1:0] ndig;
		logic [1:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} dec_t;

	// classified cell handed from front to back
	typedef struct packed {
		logic       hdr;
		logic       ftr;
		dec_t [5:0] val;
	} cell_t;

	// token sequence of one cell
	localparam logic [3:0] TK_HDR   = 4'd0;
	localparam logic [3:0] TK_FG    = 4'd1;
	localparam logic [3:0] TK_V0    = 4'd2;
	localparam logic [3:0] TK_S0    = 4'd3;
	localparam logic [3:0] TK_V1    = 4'd4;
	localparam logic [3:0] TK_S1    = 4'd5;
	localparam logic [3:0] TK_V2    = 4'd6;
	localparam logic [3:0] TK_BG    = 4'd7;
	localparam logic [3:0] TK_V3    = 4'd8;
	localparam logic [3:0] TK_S2    = 4'd9;
	localparam logic [3:0] TK_V4    = 4'd10;
	localparam logic [3:0] TK_S3    = 4'd11;
	localparam logic [3:0] TK_V5    = 4'd12;
	localparam logic [3:0] TK_GLYPH = 4'd13;
	localparam logic [3:0] TK_FTR   = 4'd14;

	localparam logic [7:0] ASCII_ZERO = 8'h30;

	// fixed text: header, fg intro, semicolon, bg intro, glyph, footer
	localparam logic [7:0] TEXT_ROM [0:40] = '{
		8'h1B, 8'h5B, 8'h3F, 8'h32, 8'h30, 8'h32, 8'h36, 8'h68, 8'h1B, 8'h5B, 8'h48,
		8'h1B, 8'h5B, 8'h33, 8'h38, 8'h3B, 8'h32, 8'h3B,
		8'h3B,
		8'h3B, 8'h34, 8'h38, 8'h3B, 8'h32, 8'h3B,
		8'h6D, 8'hE2, 8'h96, 8'h80,
		8'h1B, 8'h5B, 8'h30, 8'h6D, 8'h1B, 8'h5B, 8'h3F, 8'h32, 8'h30, 8'h32, 8'h36, 8'h6C
	};

	function automatic logic tok_is_val(input logic [3:0] tok);
		tok_is_val = (tok == TK_V0) || (tok == TK_V1) || (tok == TK_V2) ||
			(tok == TK_V3) || (tok == TK_V4) || (tok == TK_V5);
	endfunction

	function automatic logic [5:0] tok_start(input logic [3:0] tok);
		case (tok)
			TK_HDR:   tok_start = 6'd0;
			TK_FG:    tok_start = 6'd11;
			TK_BG:    tok_start = 6'd19;
			TK_GLYPH: tok_start = 6'd25;
			TK_FTR:   tok_start = 6'd29;
			default:  tok_start = 6'd18;
		endcase
	endfunction

	function automatic logic [3:0] tok_text_len(input logic [3:0] tok);
		case (tok)
			TK_HDR:   tok_text_len = 4'd11;
			TK_FG:    tok_text_len = 4'd7;
			TK_BG:    tok_text_len = 4'd6;
			TK_GLYPH: tok_text_len = 4'd4;
			TK_FTR:   tok_text_len = 4'd12;
			default:  tok_text_len = 4'd1;
		endcase
	endfunction

	function automatic dec_t to_dec(input logic [7:0] v);
		logic [1:0]  h;
		logic [6:0]  r;
		logic [14:0] prod;
		logic [3:0]  t;
		dec_t        d;
		if (v >= 8'd200)
			h = 2'd2;
		else if (v >= 8'd100)
			h = 2'd1;
		else
			h = 2'd0;
		r = 7'(v - 8'(h) * 8'd100);
		// r / 10 for r < 100
		prod = 15'(r) * 15'd205;
		t = 4'(prod >> 11);
		d.hund = h;
		d.tens = t;
		d.ones = 4'(r - 7'(t) * 7'd10);
		if (v >= 8'd100)
			d.ndig = 2'd3;
		else if (v >= 8'd10)
			d.ndig = 2'd2;
		else
			d.ndig = 2'd1;
		to_dec = d;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hbe_pixel_if.sv -----
// Pixel-pair channel: valid/ready handshake with upper and lower RGB.
// No dependencies.
`default_nettype none

interface hbe_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] upper_red;
	logic [7:0] upper_green;
	logic [7:0] upper_blue;
	logic [7:0] lower_red;
	logic [7:0] lower_green;
	logic [7:0] lower_blue;

	modport source (
		output valid, upper_red, upper_green, upper_blue,
		output lower_red, lower_green, lower_blue,
		input  ready
	);
	modport sink (
		input  valid, upper_red, upper_green, upper_blue,
		input  lower_red, lower_green, lower_blue,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/hbe_byte_if.sv -----
// Byte stream channel: valid/ready handshake with byte and framing flags.
// No dependencies.
`default_nettype none

interface hbe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_done;

	modport source (output valid, out_byte, run_last, frame_done, input ready);
	modport sink (input valid, out_byte, run_last, frame_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/half_block_ansi_color_encoder.sv -----
// Top level of the half-block color encoder: front, queue, serializer.
// Depends on hbe_pkg, hbe_pixel_if, hbe_byte_if and the three submodules.
//
//   channel  | dir | word
//   ---------+-----+---------------------------------------------------
//   pixel    | in  | upper/lower RGB pair for one character cell
//   stream   | out | one byte of the escape stream, run_last, frame_done
//   cfg      | in  | write enable, index, 12-bit data (width, height)
//
// The stream side moves one byte per cycle while the sink is ready; a cell is
// 27 to 39 bytes, plus 11 for the frame header and 12 for the footer, set by the serializer.
// The front takes a pixel word whenever the two-entry queue has room, so it
// keeps accepting while the serializer or the sink stalls, until the queue fills.
// arst_n clears counters, queue and output valid; registers reset to 80x48.
`default_nettype none

module half_block_ansi_color_encoder #(
	parameter int DIM_BITS = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [hbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [hbe_pkg::CFG_DATA_W-1:0]  cfg_data,
	hbe_pixel_if.sink                            pixel,
	hbe_byte_if.source                           stream
);

	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;
	hbe_pkg::cell_t q_wdata;
	hbe_pkg::cell_t q_head;

	hbe_front #(
		.DIM_BITS (DIM_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	hbe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty)
	);

	hbe_serializer u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.stream  (stream)
	);

endmodule

`default_nettype wire

// ----- rtl/core/hbe_front.sv -----
// Front end: config registers, position counters, cell classification.
// Depends on hbe_pkg and hbe_pixel_if.
`default_nettype none

module hbe_front #(
	parameter int DIM_BITS = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [hbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [hbe_pkg::CFG_DATA_W-1:0]  cfg_data,
	hbe_pixel_if.sink                            pixel,
	input  wire logic                            q_full,
	output logic                                 q_push,
	output hbe_pkg::cell_t                       q_wdata
);

	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;
	logic [DIM_BITS-1:0] col_q;
	logic [DIM_BITS-1:0] band_q;

	logic [DIM_BITS:0]   col_p1;
	logic [DIM_BITS:0]   band_p1;
	logic [DIM_BITS-1:0] bands;
	logic                last_col;
	logic                last_band;
	logic                no_lower;

	assign pixel.ready = !q_full;
	assign q_push      = pixel.valid && !q_full;

	always_comb begin
		col_p1    = {1'b0, col_q} + (DIM_BITS+1)'(1);
		band_p1   = {1'b0, band_q} + (DIM_BITS+1)'(1);
		bands     = DIM_BITS'(({1'b0, height_q} + (DIM_BITS+1)'(1)) >> 1);
		last_col  = col_p1 >= {1'b0, width_q};
		last_band = band_p1 >= {1'b0, bands};
		no_lower  = last_band && height_q[0];
	end

	always_comb begin
		q_wdata.hdr    = (col_q == '0) && (band_q == '0);
		q_wdata.ftr    = last_col && last_band;
		q_wdata.val[0] = hbe_pkg::to_dec(pixel.upper_red);
		q_wdata.val[1] = hbe_pkg::to_dec(pixel.upper_green);
		q_wdata.val[2] = hbe_pkg::to_dec(pixel.upper_blue);
		q_wdata.val[3] = hbe_pkg::to_dec(no_lower ? 8'd0 : pixel.lower_red);
		q_wdata.val[4] = hbe_pkg::to_dec(no_lower ? 8'd0 : pixel.lower_green);
		q_wdata.val[5] = hbe_pkg::to_dec(no_lower ? 8'd0 : pixel.lower_blue);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(80);
			height_q <= DIM_BITS'(48);
		end else if (cfg_we) begin
			if (cfg_index == hbe_pkg::REG_WIDTH)
				width_q <= DIM_BITS'(cfg_data);
			else if (cfg_index == hbe_pkg::REG_HEIGHT)
				height_q <= DIM_BITS'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			band_q <= '0;
		end else if (q_push) begin
			if (last_col && last_band) begin
				col_q  <= '0;
				band_q <= '0;
			end else if (last_col) begin
				col_q  <= '0;
				band_q <= DIM_BITS'(band_p1);
			end else begin
				col_q <= DIM_BITS'(col_p1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hbe_queue.sv -----
// Two-entry queue of classified cells between front and back.
// Depends on hbe_pkg.
`default_nettype none

module hbe_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire hbe_pkg::cell_t  wdata,
	output logic                 full,
	input  wire logic            pop,
	output hbe_pkg::cell_t       head,
	output logic                 empty
);

	hbe_pkg::cell_t                 mem_q [hbe_pkg::Q_DEPTH];
	logic [hbe_pkg::Q_AW-1:0]       wr_ptr_q;
	logic [hbe_pkg::Q_AW-1:0]       rd_ptr_q;
	logic [hbe_pkg::Q_AW:0]         cnt_q;

	assign full  = cnt_q == (hbe_pkg::Q_AW+1)'(hbe_pkg::Q_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + hbe_pkg::Q_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + hbe_pkg::Q_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (hbe_pkg::Q_AW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (hbe_pkg::Q_AW+1)'(1);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hbe_serializer.sv -----
// Back end: walks the token sequence of a cell, one byte per cycle while
// the sink is ready, into a registered output word. Depends on hbe_pkg and hbe_byte_if.
`default_nettype none

module hbe_serializer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_empty,
	input  wire hbe_pkg::cell_t  q_head,
	output logic                 q_pop,
	hbe_byte_if.source           stream
);

	hbe_pkg::cell_t cur_q;
	logic           busy_q;
	logic [3:0]     tok_q;
	logic [3:0]     pos_q;
	logic           out_valid_q;
	logic [7:0]     byte_q;
	logic           last_q;
	logic           done_q;

	logic           advance;
	logic           is_val;
	logic [2:0]     val_idx;
	hbe_pkg::dec_t  dv;
	logic [3:0]     tok_len;
	logic [3:0]     digit;
	logic [7:0]     cur_byte;
	logic           tok_end;
	logic           item_end;

	assign stream.valid      = out_valid_q;
	assign stream.out_byte   = byte_q;
	assign stream.run_last   = last_q;
	assign stream.frame_done = done_q;

	always_comb begin
		is_val  = hbe_pkg::tok_is_val(tok_q);
		val_idx = 3'((tok_q - hbe_pkg::TK_V0) >> 1);
		dv      = cur_q.val[val_idx];
		tok_len = is_val ? {2'b00, dv.ndig} : hbe_pkg::tok_text_len(tok_q);
		case (dv.ndig)
			2'd3: digit = (pos_q == 4'd0) ? {2'b00, dv.hund} :
				(pos_q == 4'd1) ? dv.tens : dv.ones;
			2'd2: digit = (pos_q == 4'd0) ? dv.tens : dv.ones;
			default: digit = dv.ones;
		endcase
		if (is_val)
			cur_byte = hbe_pkg::ASCII_ZERO | {4'h0, digit};
		else
			cur_byte = hbe_pkg::TEXT_ROM[hbe_pkg::tok_start(tok_q) + 6'(pos_q)];
		tok_end  = pos_q == (tok_len - 4'd1);
		item_end = tok_end && ((tok_q == hbe_pkg::TK_FTR) ||
			((tok_q == hbe_pkg::TK_GLYPH) && !cur_q.ftr));
		advance  = busy_q && (!out_valid_q || stream.ready);
		q_pop    = !q_empty && (!busy_q || (advance && item_end));
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_head;
		if (advance) begin
			byte_q <= cur_byte;
			last_q <= item_end;
			done_q <= item_end && (tok_q == hbe_pkg::TK_FTR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			tok_q       <= hbe_pkg::TK_HDR;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= 1'b1;
			else if (stream.ready)
				out_valid_q <= 1'b0;

			if (q_pop) begin
				busy_q <= 1'b1;
				tok_q  <= q_head.hdr ? hbe_pkg::TK_HDR : hbe_pkg::TK_FG;
				pos_q  <= '0;
			end else if (advance) begin
				if (item_end) begin
					busy_q <= 1'b0;
				end else if (tok_end) begin
					tok_q <= tok_q + 4'd1;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hbe_checker.sv -----
// Port-level checker for the half-block color encoder, bound to the top.
// Depends on half_block_ansi_color_encoder_macros.svh.
`default_nettype none

`include "half_block_ansi_color_encoder_macros.svh"

module hbe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       run_last,
	input wire logic       frame_done
);

	// a stalled word holds
	`HBE_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte))

	// footer ends the cell and the frame on 'l'
	`HBE_ASSERT_IMP(a_done, clk, arst_n, out_valid && frame_done, run_last && (out_byte == 8'h6C))

	// a cell ends on the glyph tail or the footer tail
	`HBE_ASSERT_IMP(a_last, clk, arst_n, out_valid && run_last, (out_byte == 8'h80) || (out_byte == 8'h6C))

	// every cell opens with ESC
	`HBE_ASSERT_NXT(a_open, clk, arst_n, out_valid && out_ready && run_last, !out_valid || (out_byte == 8'h1B))

endmodule

bind half_block_ansi_color_encoder hbe_checker u_hbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (stream.valid),
	.out_ready  (stream.ready),
	.out_byte   (stream.out_byte),
	.run_last   (stream.run_last),
	.frame_done (stream.frame_done)
);

`default_nettype wire

// ----- tb/half_block_ansi_color_encoder_test.sv -----
// Self-checking bench for the half-block color encoder: directed cells, then random frames.
// Predicts the escape byte stream per pixel word and checks it byte by byte.
// Depends on hbe_pkg, hbe_pixel_if, hbe_byte_if and half_block_ansi_color_encoder.
`timescale 1ns / 1ps

module half_block_ansi_color_encoder_test;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_CELLS = 400;
	localparam int CALM_CELLS   = 60;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_BURST   = 10;
	localparam int LONG_HOLD    = 500;
	localparam int MAX_REPORTS  = 10;

	// indexes past the register list; writes there must be ignored
	localparam logic [hbe_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [hbe_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam string HDR_TEXT   = "\033[?2026h\033[H";
	localparam string FTR_TEXT   = "\033[0m\033[?2026l";
	localparam string FG_TEXT    = "\033[38;2;";
	localparam string BG_TEXT    = ";48;2;";
	localparam string GLYPH_TEXT = "m\342\226\200";
	localparam string SEMI_TEXT  = ";";

	typedef struct packed {
		logic [7:0] upper_red;
		logic [7:0] upper_green;
		logic [7:0] upper_blue;
		logic [7:0] lower_red;
		logic [7:0] lower_green;
		logic [7:0] lower_blue;
	} pair_t;

	typedef struct packed {
		logic [7:0] code;
		logic       run_last;
		logic       frame_done;
	} term_byte_t;

	// literal stream for a directed cell; empty text means use the predictor
	typedef struct {
		string text;
		bit    ends_frame;
	} typed_cell_t;

	typedef enum logic {ROW_WRITE, ROW_CELL} row_kind_e;

	typedef struct {
		row_kind_e                     kind;
		logic [hbe_pkg::CFG_IDX_W-1:0] index;
		logic [hbe_pkg::CFG_DATA_W-1:0] value;
		pair_t                         pair;
		string                         text;
		bit                            ends_frame;
	} plan_row_t;

	localparam int PLAN_ROWS = 24;

	plan_row_t plan [0:PLAN_ROWS-1] = '{
		'{ROW_WRITE, hbe_pkg::REG_WIDTH, 12'd2, '0, "", 1'b0},
		'{ROW_WRITE, hbe_pkg::REG_HEIGHT, 12'd3, '0, "", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			"\033[?2026h\033[H\033[38;2;0;0;0;48;2;0;0;0m\342\226\200", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
			"\033[38;2;255;255;255;48;2;255;255;255m\342\226\200", 1'b0},
		// odd height, last band: lower color goes to zero
		'{ROW_CELL, 2'd0, 12'd0, '{8'd9, 8'd10, 8'd99, 8'd200, 8'd201, 8'd255},
			"\033[38;2;9;10;99;48;2;0;0;0m\342\226\200", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'd100, 8'd199, 8'd1, 8'd255, 8'd255, 8'd255},
			"\033[38;2;100;199;1;48;2;0;0;0m\342\226\200\033[0m\033[?2026l", 1'b1},
		// zero width and zero height: every cell is a whole frame
		'{ROW_WRITE, hbe_pkg::REG_WIDTH, 12'd0, '0, "", 1'b0},
		'{ROW_WRITE, hbe_pkg::REG_HEIGHT, 12'd0, '0, "", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'd1, 8'd2, 8'd3, 8'd123, 8'd45, 8'd6},
			"\033[?2026h\033[H\033[38;2;1;2;3;48;2;123;45;6m\342\226\200\033[0m\033[?2026l",
			1'b1},
		'{ROW_CELL, 2'd0, 12'd0, '{8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h33, 8'hCC}, "", 1'b0},
		'{ROW_WRITE, hbe_pkg::REG_HEIGHT, 12'd1, '0, "", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'd7, 8'd8, 8'd9, 8'd250, 8'd251, 8'd252},
			"\033[?2026h\033[H\033[38;2;7;8;9;48;2;0;0;0m\342\226\200\033[0m\033[?2026l",
			1'b1},
		'{ROW_WRITE, hbe_pkg::REG_WIDTH, 12'd4095, '0, "", 1'b0},
		'{ROW_WRITE, hbe_pkg::REG_HEIGHT, 12'd4095, '0, "", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC}, "", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'hFE, 8'h01, 8'h80, 8'h7F, 8'h40, 8'hC8}, "", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'd100, 8'd99, 8'd10, 8'd9, 8'd199, 8'd200}, "", 1'b0},
		'{ROW_WRITE, REG_SPARE_A, 12'd5, '0, "", 1'b0},
		'{ROW_WRITE, REG_SPARE_B, 12'd4095, '0, "", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'd3, 8'd30, 8'd250, 8'd5, 8'd50, 8'd150}, "", 1'b0},
		// shrink mid-frame: the row, then the frame, end at the next cell
		'{ROW_WRITE, hbe_pkg::REG_WIDTH, 12'd1, '0, "", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66}, "", 1'b0},
		'{ROW_WRITE, hbe_pkg::REG_HEIGHT, 12'd2, '0, "", 1'b0},
		'{ROW_CELL, 2'd0, 12'd0, '{8'd77, 8'd88, 8'd99, 8'd111, 8'd222, 8'd233}, "", 1'b0}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [hbe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [hbe_pkg::CFG_DATA_W-1:0] cfg_data;

	hbe_pixel_if pix ();
	hbe_byte_if  term ();

	half_block_ansi_color_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pix),
		.stream    (term)
	);

	// predictor state
	logic [11:0] width_reg;
	logic [11:0] height_reg;
	logic [11:0] col_pos;
	logic [11:0] band_pos;

	term_byte_t  cell_bytes [$];
	term_byte_t  stream_q [$];
	typed_cell_t typed_q [$];

	int cycle_count;
	int mismatches;
	int cells_in;
	int bytes_checked;
	int frames_seen;
	int tx_gap_pct;
	int rx_stall_pct;
	bit hold_go;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			cell_bytes.insert(cell_bytes.size(), '{8'(s[i]), 1'b0, 1'b0});
	endfunction

	function void push_decimal(input logic [7:0] v);
		if (v >= 8'd100)
			cell_bytes.insert(cell_bytes.size(),
				'{hbe_pkg::ASCII_ZERO + v / 8'd100, 1'b0, 1'b0});
		if (v >= 8'd10)
			cell_bytes.insert(cell_bytes.size(),
				'{hbe_pkg::ASCII_ZERO + (v / 8'd10) % 8'd10, 1'b0, 1'b0});
		cell_bytes.insert(cell_bytes.size(), '{hbe_pkg::ASCII_ZERO + v % 8'd10, 1'b0, 1'b0});
	endfunction

	// bytes of one cell into cell_bytes, and advance the position
	function void encode_cell(input pair_t p);
		int bands;
		bit last_col;
		bit last_band;
		bit blank_lower;
		cell_bytes.delete();
		bands = (int'(height_reg) + 1) >> 1;
		last_col = (int'(col_pos) + 1) >= int'(width_reg);
		last_band = (int'(band_pos) + 1) >= bands;
		blank_lower = last_band && height_reg[0];
		if (col_pos == 12'd0 && band_pos == 12'd0)
			push_text(HDR_TEXT);
		push_text(FG_TEXT);
		push_decimal(p.upper_red);
		push_text(SEMI_TEXT);
		push_decimal(p.upper_green);
		push_text(SEMI_TEXT);
		push_decimal(p.upper_blue);
		push_text(BG_TEXT);
		push_decimal(blank_lower ? 8'd0 : p.lower_red);
		push_text(SEMI_TEXT);
		push_decimal(blank_lower ? 8'd0 : p.lower_green);
		push_text(SEMI_TEXT);
		push_decimal(blank_lower ? 8'd0 : p.lower_blue);
		push_text(GLYPH_TEXT);
		if (last_col && last_band) begin
			push_text(FTR_TEXT);
			cell_bytes[$].frame_done = 1'b1;
			col_pos = 12'd0;
			band_pos = 12'd0;
		end else if (last_col) begin
			col_pos = 12'd0;
			band_pos = band_pos + 12'd1;
		end else begin
			col_pos = col_pos + 12'd1;
		end
		cell_bytes[$].run_last = 1'b1;
	endfunction

	function logic [7:0] rand_color();
		case ($urandom_range(0, 5))
			0:       rand_color = 8'd0;
			1:       rand_color = 8'd255;
			2:       rand_color = 8'($urandom_range(0, 9));
			3:       rand_color = 8'($urandom_range(10, 99));
			4:       rand_color = 8'($urandom_range(100, 199));
			default: rand_color = 8'($urandom_range(0, 255));
		endcase
	endfunction

	function logic [11:0] rand_dim();
		case ($urandom_range(0, 15))
			0:       rand_dim = 12'd0;
			1:       rand_dim = 12'd4095;
			2:       rand_dim = 12'($urandom_range(1, 4095));
			default: rand_dim = 12'($urandom_range(1, 6));
		endcase
	endfunction

	function int rand_pct();
		case ($urandom_range(0, 2))
			0:       rand_pct = 0;
			1:       rand_pct = 15;
			default: rand_pct = 40;
		endcase
	endfunction

	// predictor, config tracking and stream check share one block so their order is fixed
	always @(posedge clk) begin : scoreboard
		typed_cell_t typed;
		term_byte_t  want;
		term_byte_t  got;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					hbe_pkg::REG_WIDTH:  width_reg = cfg_data;
					hbe_pkg::REG_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (pix.valid && pix.ready) begin
				encode_cell('{pix.upper_red, pix.upper_green, pix.upper_blue,
					pix.lower_red, pix.lower_green, pix.lower_blue});
				typed.text = "";
				typed.ends_frame = 1'b0;
				if (typed_q.size() != 0)
					typed = typed_q.pop_front();
				if (typed.text.len() == 0) begin
					foreach (cell_bytes[i])
						stream_q.insert(stream_q.size(), cell_bytes[i]);
				end else begin
					for (int i = 0; i < typed.text.len(); i++)
						stream_q.insert(stream_q.size(),
							'{8'(typed.text[i]), i == typed.text.len() - 1,
							typed.ends_frame && i == typed.text.len() - 1});
				end
				cells_in++;
			end
			if (term.valid && term.ready) begin
				got = '{term.out_byte, term.run_last, term.frame_done};
				if (got.frame_done)
					frames_seen++;
				if (stream_q.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("unexpected byte %h run_last %b frame_done %b",
							got.code, got.run_last, got.frame_done);
					mismatches++;
				end else begin
					want = stream_q.pop_front();
					bytes_checked++;
					if (got.code !== want.code || got.run_last !== want.run_last ||
						got.frame_done !== want.frame_done) begin
						if (mismatches < MAX_REPORTS)
							$display("byte %0d: expected %h/%b/%b, got %h/%b/%b",
								bytes_checked, want.code, want.run_last, want.frame_done,
								got.code, got.run_last, got.frame_done);
						mismatches++;
					end
				end
			end
		end
	end

	// output side: random stalls plus one long hold to back the block up
	initial begin : sink_side
		int  stall_left;
		int  hold_left;
		bit  hold_armed;
		stall_left = 0;
		hold_left = 0;
		hold_armed = 1'b1;
		term.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				term.ready <= 1'b0;
				hold_left--;
			end else if (hold_armed && hold_go) begin
				hold_armed = 1'b0;
				hold_left = LONG_HOLD - 1;
				term.ready <= 1'b0;
			end else if (stall_left > 0) begin
				term.ready <= 1'b0;
				stall_left--;
			end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				stall_left = $urandom_range(1, 14) - 1;
				term.ready <= 1'b0;
			end else begin
				term.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d bytes still expected",
			cycle_count, stream_q.size());
		$display("Simulation FAILED");
		$finish;
	end

	task automatic offer_cell(input pair_t p, input string text, input bit ends);
		typed_cell_t typed;
		typed.text = text;
		typed.ends_frame = ends;
		typed_q.insert(typed_q.size(), typed);
		pix.valid <= 1'b1;
		pix.upper_red <= p.upper_red;
		pix.upper_green <= p.upper_green;
		pix.upper_blue <= p.upper_blue;
		pix.lower_red <= p.lower_red;
		pix.lower_green <= p.lower_green;
		pix.lower_blue <= p.lower_blue;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
	endtask

	task automatic idle_gap();
		if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 14))
				@(posedge clk);
		end
	endtask

	// wait until every accepted word has been fully streamed out
	task automatic drain();
		pix.valid <= 1'b0;
		while (typed_q.size() != 0 || stream_q.size() != 0)
			@(posedge clk);
		repeat (2)
			@(posedge clk);
	endtask

	initial begin : stimulus
		bit writing;
		int random_sent;
		int burst;
		bit calm;
		bit hold_here;
		width_reg = 12'd80;
		height_reg = 12'd48;
		col_pos = 12'd0;
		band_pos = 12'd0;
		mismatches = 0;
		cells_in = 0;
		bytes_checked = 0;
		frames_seen = 0;
		tx_gap_pct = 25;
		rx_stall_pct = 25;
		hold_go = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.upper_red = 8'd0;
		pix.upper_green = 8'd0;
		pix.upper_blue = 8'd0;
		pix.lower_red = 8'd0;
		pix.lower_green = 8'd0;
		pix.lower_blue = 8'd0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		writing = 1'b0;
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (!writing)
					drain();
				cfg_we <= 1'b1;
				cfg_index <= plan[i].index;
				cfg_data <= plan[i].value;
				@(posedge clk);
				writing = 1'b1;
			end else begin
				if (writing)
					cfg_we <= 1'b0;
				writing = 1'b0;
				idle_gap();
				offer_cell(plan[i].pair, plan[i].text, plan[i].ends_frame);
			end
		end

		random_sent = 0;
		while (random_sent < RANDOM_CELLS) begin
			burst = $urandom_range(5, 40);
			// the long sink hold rides on a burst that keeps offering words
			hold_here = !hold_go && cells_in >= HOLD_AT;
			if (hold_here && burst < HOLD_BURST)
				burst = HOLD_BURST;
			if (random_sent + burst > RANDOM_CELLS)
				burst = RANDOM_CELLS - random_sent;
			calm = random_sent >= RANDOM_CELLS - CALM_CELLS;
			tx_gap_pct = calm ? 0 : rand_pct();
			rx_stall_pct = calm ? 0 : rand_pct();
			// sometimes keep the old size so the frame carries across phases
			if ($urandom_range(0, 3) != 0) begin
				drain();
				cfg_we <= 1'b1;
				cfg_index <= hbe_pkg::REG_WIDTH;
				cfg_data <= rand_dim();
				@(posedge clk);
				cfg_index <= hbe_pkg::REG_HEIGHT;
				cfg_data <= rand_dim();
				@(posedge clk);
				if ($urandom_range(0, 4) == 0) begin
					cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
					cfg_data <= 12'($urandom);
					@(posedge clk);
				end
				cfg_we <= 1'b0;
			end
			if (hold_here)
				hold_go = 1'b1;
			repeat (burst) begin
				idle_gap();
				offer_cell('{rand_color(), rand_color(), rand_color(),
					rand_color(), rand_color(), rand_color()}, "", 1'b0);
				random_sent++;
			end
		end

		drain();
		repeat (20)
			@(posedge clk);
		mismatches += stream_q.size();
		$display("%0d pixel words in, %0d stream bytes checked, %0d frames closed",
			cells_in, bytes_checked, frames_seen);
		$display("sizes from 0 to 4095 incl. odd heights, mid-frame resize, %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
